// File: design/fifo_wm_pkg.sv
// Shared constants, codes and threshold helpers for the watermark FIFO.
// Depends on nothing; imported by fifo_with_fill_watermarks.
package fifo_wm_pkg;

    // Storage geometry
    localparam int DEPTH   = 256;
    localparam int ITEM_W  = 32;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam int CAP_W   = 9;
    localparam int LEVEL_W = 3;
    localparam int EVT_W   = 2;
    localparam int KIND_W  = 2;

    // Configuration port
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Watermark change codes
    localparam logic [EVT_W-1:0] EVT_NONE = 2'd0;
    localparam logic [EVT_W-1:0] EVT_ROSE = 2'd1;
    localparam logic [EVT_W-1:0] EVT_FELL = 2'd2;

    // Watermark percentages
    localparam int NUM_MARKS = 5;
    localparam logic [6:0] RISE_PCT [NUM_MARKS] = '{7'd2, 7'd26, 7'd51, 7'd76, 7'd100};
    localparam logic [6:0] FALL_PCT [NUM_MARKS] = '{7'd0, 7'd24, 7'd49, 7'd74, 7'd98};

    // floor(x / 100) as (x * RECIP_K) >> RECIP_SHIFT, exact for x up to 100 * DEPTH
    localparam int RECIP_SHIFT = 21;
    localparam logic [30:0] RECIP_K = 31'd20972;

    // Clamp the programmed capacity into 1 .. DEPTH
    function automatic logic [CAP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] eff;
        eff = cap;
        if (cap == '0)
        begin
            eff = CAP_W'(1);
        end
        else if (cap > CAP_W'(DEPTH))
        begin
            eff = CAP_W'(DEPTH);
        end
        return eff;
    endfunction

    // floor(pct * capacity / 100) for the effective capacity
    function automatic logic [CNT_W-1:0] mark_threshold(input logic [CAP_W-1:0] cap,
                                                        input logic [6:0] pct);
        logic [CAP_W-1:0] eff;
        logic [15:0]      scaled;
        logic [30:0]      prod;
        eff    = eff_capacity(cap);
        scaled = 16'(eff) * 16'(pct);
        prod   = 31'(scaled) * RECIP_K;
        return CNT_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage

// File: design/fifo_wm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the item store of the watermark FIFO.
module fifo_wm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fifo_with_fill_watermarks.sv
// Watermark FIFO top level: request decode, pointers, count, level hysteresis.
// Depends on fifo_wm_pkg and fifo_wm_ram.
//
// Each request (enqueue, dequeue or clear) is one transfer on the input
// channel and gives exactly one result transfer in the next cycle.
// A new request can be taken in every cycle; the result comes from registers and
// the registered read of the item store RAM, and the only pause is while a
// result is held by out_stall. The capacity register (1 .. 256, 0 acts as 1)
// sits at byte address 0; its five rising and five falling thresholds are
// worked out when it is written. The store is not cleared at reset: only
// entries that were enqueued may be dequeued. Change capacity only while idle.
module fifo_with_fill_watermarks
    import fifo_wm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [ITEM_W-1:0]   item_data,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                accepted,
    output logic [ITEM_W-1:0]   item_out,
    output logic [CNT_W-1:0]    fill_count,
    output logic [LEVEL_W-1:0]  fill_level,
    output logic [EVT_W-1:0]    level_event,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [CAP_W-1:0]   capacity_reg;
    logic [CAP_W-1:0]   cap_eff_reg;
    logic [CNT_W-1:0]   rise_thr_reg [NUM_MARKS];
    logic [CNT_W-1:0]   fall_thr_reg [NUM_MARKS];

    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic               out_valid_reg;
    logic               accepted_reg, accepted_next;
    logic               deq_reg, deq_next;
    logic [EVT_W-1:0]   event_reg, event_next;

    logic               in_fire;
    logic               out_fire;
    logic               cfg_write;
    logic               enq_ok;
    logic               ram_re;
    logic [ITEM_W-1:0]  ram_rdata;

    // Handshakes
    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration port: capacity and its derived thresholds
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? DATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            cap_eff_reg  <= eff_capacity(CAP_RESET);
            for (int i = 0; i < NUM_MARKS; i++)
            begin
                rise_thr_reg[i] <= mark_threshold(CAP_RESET, RISE_PCT[i]);
                fall_thr_reg[i] <= mark_threshold(CAP_RESET, FALL_PCT[i]);
            end
        end
        else if (cfg_write && paddr[ADDR_W-1:2] == REG_CAPACITY)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
            cap_eff_reg  <= eff_capacity(pwdata[CAP_W-1:0]);
            for (int i = 0; i < NUM_MARKS; i++)
            begin
                rise_thr_reg[i] <= mark_threshold(pwdata[CAP_W-1:0], RISE_PCT[i]);
                fall_thr_reg[i] <= mark_threshold(pwdata[CAP_W-1:0], FALL_PCT[i]);
            end
        end
    end

    // Decode the request and work out the next state and result
    always_comb
    begin
        logic             fall_hit;
        logic [CNT_W-1:0] rd_inc;
        logic [CNT_W-1:0] wr_inc;
        fall_hit      = 1'b0;
        rd_inc        = CNT_W'(rd_ptr_reg) + CNT_W'(1);
        wr_inc        = CNT_W'(wr_ptr_reg) + CNT_W'(1);
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        count_next    = count_reg;
        level_next    = level_reg;
        accepted_next = 1'b0;
        deq_next      = 1'b0;
        enq_ok        = 1'b0;
        unique case (kind)
            KIND_ENQ:
            begin
                if (count_reg < CNT_W'(cap_eff_reg))
                begin
                    enq_ok        = 1'b1;
                    accepted_next = 1'b1;
                    // last matching rising mark at or above the level wins
                    for (int i = 0; i < NUM_MARKS; i++)
                    begin
                        if (LEVEL_W'(i) >= level_reg && count_reg == rise_thr_reg[i])
                        begin
                            level_next = LEVEL_W'(i + 1);
                        end
                    end
                    wr_ptr_next = (wr_inc >= CNT_W'(cap_eff_reg)) ? '0 : wr_inc[PTR_W-1:0];
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            KIND_DEQ:
            begin
                if (count_reg != '0)
                begin
                    deq_next      = 1'b1;
                    accepted_next = 1'b1;
                    // first matching falling mark below the level wins
                    for (int i = 0; i < NUM_MARKS; i++)
                    begin
                        if (!fall_hit && LEVEL_W'(i) < level_reg
                            && count_reg == fall_thr_reg[i])
                        begin
                            level_next = LEVEL_W'(i);
                            fall_hit   = 1'b1;
                        end
                    end
                    rd_ptr_next = (rd_inc >= CNT_W'(cap_eff_reg)) ? '0 : rd_inc[PTR_W-1:0];
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            KIND_CLEAR:
            begin
                accepted_next = 1'b1;
                rd_ptr_next   = '0;
                wr_ptr_next   = '0;
                count_next    = '0;
                level_next    = '0;
            end
            default:
            begin
                // unused code: no operation
            end
        endcase

        if (level_next > level_reg)
        begin
            event_next = EVT_ROSE;
        end
        else if (level_next < level_reg)
        begin
            event_next = EVT_FELL;
        end
        else
        begin
            event_next = EVT_NONE;
        end
    end

    // Advance state and result on each accepted transfer; drop out_valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            deq_reg       <= 1'b0;
            event_reg     <= EVT_NONE;
        end
        else
        begin
            if (in_fire)
            begin
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
                count_reg     <= count_next;
                level_reg     <= level_next;
                out_valid_reg <= 1'b1;
                accepted_reg  <= accepted_next;
                deq_reg       <= deq_next;
                event_reg     <= event_next;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item store
    assign ram_re = in_fire && deq_next;

    fifo_wm_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && enq_ok),
        .waddr (wr_ptr_reg),
        .wdata (item_data),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Result outputs; count and level are the state left by the last request
    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign item_out    = deq_reg ? ram_rdata : '0;
    assign fill_count  = count_reg;
    assign fill_level  = level_reg;
    assign level_event = event_reg;

    // Checks
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with no result pending");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> count_reg != '0)
        else $error("store read while empty");

    a_enq_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && enq_ok) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted enqueue did not raise the count");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && kind == KIND_CLEAR) |=> (count_reg == '0 && level_reg == '0
                                             && accepted_reg))
        else $error("clear left count or level set");

    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(NUM_MARKS - 1))
        else $error("watermark level reached the top mark");

endmodule
